### rtl/core/fci_pkg.sv
package fci_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int PT_W      = 15;
    localparam int TEMP_W    = 8;
    localparam int PCT_W     = 7;
    localparam int CNT_W     = 4;
    localparam int QUOT_W    = 15;
    localparam int PROD_W    = 17;
    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 2;
    localparam int PTS_W     = NUM_SLOTS * PT_W;
    localparam int PCT_LIMIT = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FOUR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_FOUR   = 2'd2;

    typedef struct packed {
        logic              neg;
        logic [TEMP_W-1:0] rem;
        logic [QUOT_W-1:0] work;
        logic [TEMP_W-1:0] den;
        logic [PCT_W-1:0]  base;
    } t_div;

endpackage

### rtl/core/fci_select.sv
module fci_select #(
    parameter int MAX_POINTS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [fci_pkg::TEMP_W-1:0]   i_temperature,
    input  logic [fci_pkg::CNT_W-1:0]    i_point_count,
    input  logic [fci_pkg::PTS_W-1:0]    i_points,
    output logic                         o_valid,
    output fci_pkg::t_div                o_data
);

    logic [fci_pkg::CNT_W-1:0]  w_n;
    logic [fci_pkg::TEMP_W-1:0] w_lo_t;
    logic [fci_pkg::PCT_W-1:0]  w_lo_p;
    logic [fci_pkg::TEMP_W-1:0] w_hi_t;
    logic [fci_pkg::PCT_W-1:0]  w_hi_p;

    logic                       r_s1_valid;
    logic [fci_pkg::TEMP_W-1:0] r_s1_t;
    logic [fci_pkg::TEMP_W-1:0] r_s1_lo_t;
    logic [fci_pkg::PCT_W-1:0]  r_s1_lo_p;
    logic [fci_pkg::TEMP_W-1:0] r_s1_hi_t;
    logic [fci_pkg::PCT_W-1:0]  r_s1_hi_p;

    logic signed [fci_pkg::TEMP_W:0]   w_num;
    logic signed [fci_pkg::TEMP_W:0]   w_den;
    logic signed [fci_pkg::PCT_W:0]    w_diff;
    logic signed [fci_pkg::PROD_W-1:0] w_prod;
    logic signed [fci_pkg::PROD_W-1:0] w_mag;
    fci_pkg::t_div                     n_s2_data;

    logic          r_s2_valid;
    fci_pkg::t_div r_s2_data;

    always_comb begin
        if (i_point_count == '0) begin
            w_n = fci_pkg::CNT_W'(1);
        end else if (i_point_count > fci_pkg::CNT_W'(MAX_POINTS)) begin
            w_n = fci_pkg::CNT_W'(MAX_POINTS);
        end else begin
            w_n = i_point_count;
        end
    end

    always_comb begin
        w_lo_t = i_points[0 +: fci_pkg::TEMP_W];
        w_lo_p = i_points[fci_pkg::TEMP_W +: fci_pkg::PCT_W];
        w_hi_t = w_lo_t;
        w_hi_p = w_lo_p;
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (fci_pkg::CNT_W'(k) < w_n) begin
                w_hi_t = i_points[k*fci_pkg::PT_W +: fci_pkg::TEMP_W];
                w_hi_p = i_points[k*fci_pkg::PT_W + fci_pkg::TEMP_W +: fci_pkg::PCT_W];
                if (i_points[k*fci_pkg::PT_W +: fci_pkg::TEMP_W] <= i_temperature) begin
                    w_lo_t = i_points[k*fci_pkg::PT_W +: fci_pkg::TEMP_W];
                    w_lo_p = i_points[k*fci_pkg::PT_W + fci_pkg::TEMP_W +: fci_pkg::PCT_W];
                end
            end
        end
        for (int k = MAX_POINTS - 1; k >= 0; k--) begin
            if ((fci_pkg::CNT_W'(k) < w_n) &&
                (i_points[k*fci_pkg::PT_W +: fci_pkg::TEMP_W] > i_temperature)) begin
                w_hi_t = i_points[k*fci_pkg::PT_W +: fci_pkg::TEMP_W];
                w_hi_p = i_points[k*fci_pkg::PT_W + fci_pkg::TEMP_W +: fci_pkg::PCT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_t    <= i_temperature;
            r_s1_lo_t <= w_lo_t;
            r_s1_lo_p <= w_lo_p;
            r_s1_hi_t <= w_hi_t;
            r_s1_hi_p <= w_hi_p;
            r_s2_data <= n_s2_data;
        end
    end

    always_comb begin
        w_num  = $signed({1'b0, r_s1_t}) - $signed({1'b0, r_s1_lo_t});
        w_den  = $signed({1'b0, r_s1_hi_t}) - $signed({1'b0, r_s1_lo_t});
        w_diff = $signed({1'b0, r_s1_hi_p}) - $signed({1'b0, r_s1_lo_p});
        if (w_den < 0) begin
            w_den = -w_den;
            w_num = -w_num;
        end
        w_prod = w_num * w_diff;
        w_mag  = (w_prod < 0) ? -w_prod : w_prod;

        n_s2_data.neg  = w_prod < 0;
        n_s2_data.rem  = '0;
        n_s2_data.work = w_mag[fci_pkg::QUOT_W-1:0];
        n_s2_data.den  = w_den[fci_pkg::TEMP_W-1:0];
        n_s2_data.base = r_s1_lo_p;
        if (r_s1_lo_t == r_s1_hi_t) begin
            n_s2_data.neg  = 1'b0;
            n_s2_data.work = '0;
            n_s2_data.den  = fci_pkg::TEMP_W'(1);
            n_s2_data.base = r_s1_hi_p;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_data  = r_s2_data;

endmodule

### rtl/core/fci_div_cell.sv
module fci_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  fci_pkg::t_div i_data,
    output logic          o_valid,
    output fci_pkg::t_div o_data
);

    logic [fci_pkg::TEMP_W:0] w_trial;
    logic                     w_fit;
    fci_pkg::t_div            n_data;
    logic                     r_valid;
    fci_pkg::t_div            r_data;

    always_comb begin
        w_trial     = {i_data.rem, i_data.work[fci_pkg::QUOT_W-1]};
        w_fit       = w_trial >= {1'b0, i_data.den};
        n_data      = i_data;
        n_data.rem  = w_fit ? fci_pkg::TEMP_W'(w_trial - {1'b0, i_data.den})
                            : fci_pkg::TEMP_W'(w_trial);
        n_data.work = {i_data.work[fci_pkg::QUOT_W-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/fan_curve_interpolator.sv
// Pipeline from input transaction to result valid: 2 select/product stages,
// 15 restoring division cells, 1 output register.
// Throughput: one transaction per cycle while the output is not stalled; the division cell chain sets the depth.
// Output stall holds the whole pipeline; input ready follows output space.
// Synchronous active-low reset clears all valid flags, point_count to 1
// and both point registers to zero.
module fan_curve_interpolator #(
    parameter int MAX_POINTS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [fci_pkg::TEMP_W-1:0]      i_temperature,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fci_pkg::PCT_W-1:0]       o_fan_percent,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fci_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fci_pkg::CFG_W-1:0]       i_cfg_data
);

    logic [fci_pkg::CNT_W-1:0] r_point_count;
    logic [fci_pkg::CFG_W-1:0] r_points_first;
    logic [fci_pkg::CFG_W-1:0] r_points_last;

    logic                      w_en;
    logic [fci_pkg::QUOT_W:0]  w_valid;
    fci_pkg::t_div             w_data [0:fci_pkg::QUOT_W];

    logic                               r_out_valid;
    logic [fci_pkg::PCT_W-1:0]          r_out_pct;
    logic signed [fci_pkg::PROD_W-1:0]  w_q;
    logic signed [fci_pkg::PROD_W-1:0]  w_res;
    logic [fci_pkg::PCT_W-1:0]          n_out_pct;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count  <= fci_pkg::CNT_W'(1);
            r_points_first <= '0;
            r_points_last  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fci_pkg::CFG_POINT_COUNT: r_point_count  <= i_cfg_data[fci_pkg::CNT_W-1:0];
                fci_pkg::CFG_FIRST_FOUR:  r_points_first <= i_cfg_data;
                fci_pkg::CFG_LAST_FOUR:   r_points_last  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    fci_select #(
        .MAX_POINTS (MAX_POINTS)
    ) u_select (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_in_valid),
        .i_temperature (i_temperature),
        .i_point_count (r_point_count),
        .i_points      ({r_points_last, r_points_first}),
        .o_valid       (w_valid[0]),
        .o_data        (w_data[0])
    );

    for (genvar g = 0; g < fci_pkg::QUOT_W; g++) begin : g_cell
        fci_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    always_comb begin
        w_q = $signed({2'b00, w_data[fci_pkg::QUOT_W].work});
        if (w_data[fci_pkg::QUOT_W].neg) begin
            w_q = -(w_q + $signed(fci_pkg::PROD_W'(w_data[fci_pkg::QUOT_W].rem != '0)));
        end
        w_res = $signed(fci_pkg::PROD_W'(w_data[fci_pkg::QUOT_W].base)) + w_q;
        if (w_res < 0) begin
            n_out_pct = '0;
        end else if (w_res > fci_pkg::PROD_W'(fci_pkg::PCT_LIMIT)) begin
            n_out_pct = fci_pkg::PCT_W'(fci_pkg::PCT_LIMIT);
        end else begin
            n_out_pct = w_res[fci_pkg::PCT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[fci_pkg::QUOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pct <= n_out_pct;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_fan_percent = r_out_pct;

`ifndef ASSERT_OFF
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fan_percent <= fci_pkg::PCT_W'(fci_pkg::PCT_LIMIT)))
        else $error("fan_percent above limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(w_valid))
        else $error("pipeline moved during output stall");

    a_chain_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[fci_pkg::QUOT_W] && w_en) |=> o_out_valid)
        else $error("division chain result dropped");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import fci_pkg::*;

    localparam int CURVE_POINTS = 8;
    localparam int PIPE_DEPTH   = 18;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 84;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [TEMP_W-1:0] reading;
        logic [PCT_W-1:0]  duty;
    } t_duty_exp;

    class duty_scoreboard;
        logic [CNT_W-1:0] count_reg;
        logic [CFG_W-1:0] first_reg;
        logic [CFG_W-1:0] last_reg;
        t_duty_exp        duty_q[$];
        int               mismatches;
        int               checked;

        function new();
            count_reg  = 4'd1;
            first_reg  = '0;
            last_reg   = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_POINT_COUNT: count_reg = data[CNT_W-1:0];
                CFG_FIRST_FOUR:  first_reg = data;
                CFG_LAST_FOUR:   last_reg  = data;
                default: ;
            endcase
        endfunction

        function logic [PT_W-1:0] point(int k);
            logic [CFG_W-1:0] bank;
            bank = (k < 4) ? first_reg : last_reg;
            return bank[(k % 4) * PT_W +: PT_W];
        endfunction

        function int temp_of(int k);
            logic [PT_W-1:0] w;
            w = point(k);
            return int'(w[TEMP_W-1:0]);
        endfunction

        function int pct_of(int k);
            logic [PT_W-1:0] w;
            w = point(k);
            return int'(w[PT_W-1:TEMP_W]);
        endfunction

        function logic [PCT_W-1:0] duty_for(logic [TEMP_W-1:0] reading);
            int          n;
            int          i;
            int          lo;
            int          hi;
            int          tv;
            int          lo_t;
            int          hi_t;
            int          num;
            int          den;
            int          prod;
            int          q;
            int          res;
            logic [31:0] res_bits;
            tv = int'(reading);
            n  = int'(count_reg);
            if (n == 0) n = 1;
            if (n > CURVE_POINTS) n = CURVE_POINTS;
            lo = 0;
            hi = n - 1;
            for (i = 0; i < n; i++) begin
                if (temp_of(i) <= tv) lo = i;
            end
            for (i = n - 1; i >= 0; i--) begin
                if (temp_of(i) > tv) hi = i;
            end
            lo_t = temp_of(lo);
            hi_t = temp_of(hi);
            if (lo_t == hi_t) begin
                res = pct_of(hi);
            end else begin
                num = tv - lo_t;
                den = hi_t - lo_t;
                if (den < 0) begin
                    den = -den;
                    num = -num;
                end
                prod = num * (pct_of(hi) - pct_of(lo));
                q    = prod / den;
                if ((prod % den) != 0 && prod < 0) q = q - 1;
                res = pct_of(lo) + q;
            end
            if (res < 0) res = 0;
            if (res > PCT_LIMIT) res = PCT_LIMIT;
            res_bits = res;
            return res_bits[PCT_W-1:0];
        endfunction

        function void note_reading(logic [TEMP_W-1:0] reading);
            t_duty_exp e;
            e.reading = reading;
            e.duty    = duty_for(reading);
            duty_q.push_back(e);
        endfunction

        function void check_duty(logic [PCT_W-1:0] actual);
            t_duty_exp e;
            if (duty_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected fan duty %0d with no reading outstanding", actual);
                return;
            end
            e = duty_q.pop_front();
            checked++;
            if (actual !== e.duty) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Fan duty mismatch at %0d C: expected %0d, got %0d",
                             e.reading, e.duty, actual);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [TEMP_W-1:0]    i_temperature;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [PCT_W-1:0]     o_fan_percent;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    duty_scoreboard sb;
    logic [TEMP_W-1:0] curve_t [CURVE_POINTS];
    logic [PCT_W-1:0]  curve_p [CURVE_POINTS];
    bit                calm = 1'b0;
    int                gap_odds = 0;
    int                readings_sent = 0;
    int                curve_loads = 0;
    int                cycle_count = 0;

    fan_curve_interpolator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_temperature (i_temperature),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_fan_percent (o_fan_percent),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_duty(o_fan_percent);
    end

    initial begin : out_side
        int n;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (calm || $urandom_range(0, 4) != 0) begin
                i_out_ready <= 1'b1;
                n = $urandom_range(1, 30);
            end else begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 19);
            end
            repeat (n) @(negedge i_clk);
        end
    end

    function automatic logic [CFG_W-1:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_W-1:0];
    endfunction

    function automatic logic [PTS_W-1:0] pack_curve();
        logic [PTS_W-1:0] w;
        for (int k = 0; k < CURVE_POINTS; k++) w[k * PT_W +: PT_W] = {curve_p[k], curve_t[k]};
        return w;
    endfunction

    task automatic make_rising_curve();
        int t;
        int p;
        t = $urandom_range(0, 60);
        for (int k = 0; k < CURVE_POINTS; k++) begin
            p = $urandom_range(0, 100);
            curve_t[k] = t[TEMP_W-1:0];
            curve_p[k] = p[PCT_W-1:0];
            t = t + $urandom_range(1, 45);
            if (t > 255) t = 255;
        end
    endtask

    task automatic send_reading(input logic [TEMP_W-1:0] reading);
        i_in_valid    <= 1'b1;
        i_temperature <= reading;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_reading(reading);
        readings_sent++;
        @(negedge i_clk);
        if (gap_odds != 0 && !calm && $urandom_range(0, gap_odds - 1) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
    endtask

    // drain the pipeline before touching the curve
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.duty_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 6) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, data);
        @(negedge i_clk);
    endtask

    task automatic load_curve(input logic [CNT_W-1:0] count, input logic [CFG_W-1:0] first,
                              input logic [CFG_W-1:0] last, input bit spare);
        logic [CFG_W-1:0] w;
        w = rand_word();
        w[CNT_W-1:0] = count;
        write_register(CFG_POINT_COUNT, w);
        write_register(CFG_FIRST_FOUR, first);
        write_register(CFG_LAST_FOUR, last);
        if (spare) write_register(CFG_SPARE, rand_word());
        i_cfg_valid <= 1'b0;
        curve_loads++;
    endtask

    initial begin : stimulus
        logic [PTS_W-1:0]  packed_pts;
        logic [CFG_W-1:0]  first;
        logic [CFG_W-1:0]  last;
        logic [CNT_W-1:0]  count;
        logic [31:0]       near;
        logic [31:0]       pick;
        int                mode;

        sb = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_temperature = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // curve left by reset
        send_reading(8'd0);
        send_reading(8'd255);
        settle();

        curve_t = '{8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90};
        curve_p = '{7'd0, 7'd10, 7'd25, 7'd40, 7'd60, 7'd80, 7'd95, 7'd100};
        packed_pts = pack_curve();
        load_curve(4'd8, packed_pts[CFG_W-1:0], packed_pts[PTS_W-1:CFG_W], 1'b0);
        send_reading(8'd0);
        send_reading(8'd20);
        send_reading(8'd25);
        send_reading(8'd47);
        send_reading(8'd55);
        send_reading(8'd89);
        send_reading(8'd90);
        send_reading(8'd91);
        send_reading(8'd255);
        settle();

        // falling curve with a percent above the limit
        curve_t = '{8'd10, 8'd50, 8'd100, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0};
        curve_p = '{7'd127, 7'd100, 7'd40, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
        packed_pts = pack_curve();
        load_curve(4'd4, packed_pts[CFG_W-1:0], rand_word(), 1'b0);
        send_reading(8'd0);
        send_reading(8'd10);
        send_reading(8'd30);
        send_reading(8'd75);
        send_reading(8'd150);
        send_reading(8'd201);
        send_reading(8'd255);
        settle();

        // unsorted curve, count above the maximum
        curve_t = '{8'd200, 8'd100, 8'd50, 8'd255, 8'd0, 8'd128, 8'd30, 8'd240};
        curve_p = '{7'd0, 7'd100, 7'd20, 7'd127, 7'd5, 7'd64, 7'd90, 7'd10};
        packed_pts = pack_curve();
        load_curve(4'd15, packed_pts[CFG_W-1:0], packed_pts[PTS_W-1:CFG_W], 1'b0);
        send_reading(8'd0);
        send_reading(8'd60);
        send_reading(8'd128);
        send_reading(8'd254);
        settle();

        // zero count and a write to the spare index
        load_curve(4'd0, rand_word(), rand_word(), 1'b1);
        send_reading(8'd7);
        send_reading(8'd200);
        settle();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            calm = (phase >= RAND_PHASES - 2);
            mode = $urandom_range(0, 3);
            gap_odds = (mode == 0) ? 0 : (mode == 1) ? 2 : (mode == 2) ? 5 : 12;
            if (phase == 1) begin
                count = 4'd15;
                first = '1;
                last  = '1;
            end else if (phase == 0 || phase == 2 || $urandom_range(0, 4) != 0) begin
                make_rising_curve();
                packed_pts = pack_curve();
                first = packed_pts[CFG_W-1:0];
                last  = packed_pts[PTS_W-1:CFG_W];
                pick  = $urandom_range(1, 8);
                count = (phase == 0) ? 4'd8 : (phase == 2) ? 4'd1 : pick[CNT_W-1:0];
            end else begin
                pick  = $urandom_range(0, 15);
                count = pick[CNT_W-1:0];
                first = rand_word();
                last  = rand_word();
            end
            load_curve(count, first, last, $urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    near = sb.temp_of($urandom_range(0, 7)) + $urandom_range(0, 2) - 1;
                    send_reading(near[TEMP_W-1:0]);
                end else begin
                    pick = $urandom_range(0, 255);
                    send_reading(pick[TEMP_W-1:0]);
                end
            end
            settle();
        end

        $display("Checked %0d fan duties from %0d readings over %0d curve loads",
                 sb.checked, readings_sent, curve_loads);
        $display("Curves: rising, falling, unsorted, raw words, counts from 0 to 15");
        if (sb.mismatches == 0 && sb.duty_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/fci_pkg.sv
rtl/core/fci_select.sv
rtl/core/fci_div_cell.sv
rtl/core/fan_curve_interpolator.sv
tb/tb.sv
